### hdl/hmmap_pkg.sv
`default_nettype none

package hmmap_pkg;

    localparam int RAM_AW      = 15;
    localparam int RAM_DEPTH   = 1 << RAM_AW;
    localparam int BOOT_AW     = 8;
    localparam int BOOT_DEPTH  = 1 << BOOT_AW;
    localparam int OFFSET_W    = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] ROM_TOP     = 16'h7FFF;
    localparam logic [15:0] BOOT_TOP    = 16'h00FF;
    localparam logic [15:0] ECHO_LO     = 16'hE000;
    localparam logic [15:0] ECHO_HI     = 16'hFDFF;
    localparam logic [15:0] ECHO_SHIFT  = 16'h2000;
    localparam logic [15:0] JOYPAD_ADDR = 16'hFF00;
    localparam logic [15:0] DMA_ADDR    = 16'hFF46;
    localparam logic [15:0] BOOT_OFF_ADDR = 16'hFF50;
    localparam logic [15:0] OAM_BASE    = 16'hFE00;

    localparam logic [RAM_AW-1:0] BOOT_OFF_IDX = BOOT_OFF_ADDR[RAM_AW-1:0];
    localparam logic [RAM_AW-1:0] DMA_REG_IDX  = DMA_ADDR[RAM_AW-1:0];
    localparam logic [RAM_AW-1:0] OAM_BASE_IDX = OAM_BASE[RAM_AW-1:0];

    localparam logic [7:0] ECHO_PAGE_LO  = ECHO_LO[15:8];
    localparam logic [7:0] ECHO_PAGE_HI  = ECHO_HI[15:8];
    localparam logic [7:0] ECHO_PAGE_SUB = ECHO_SHIFT[15:8];
    localparam logic [7:0] JOYPAD_MASK   = 8'h0F;
    localparam logic [7:0] BOOT_OFF_VAL  = 8'h01;

    typedef enum logic [1:0] {
        CMD_READ      = 2'd0,
        CMD_WRITE     = 2'd1,
        CMD_LOAD_CART = 2'd2,
        CMD_LOAD_BOOT = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_RD_ROM,
        OP_RD_RAM,
        OP_WR_RAM,
        OP_DMA,
        OP_LD_CART,
        OP_LD_BOOT
    } op_t;

    typedef enum logic [1:0] {
        SRC_RAM,
        SRC_CART,
        SRC_BOOT
    } src_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESP,
        ST_DMA_RD,
        ST_DMA_WR,
        ST_DMA_FIN
    } back_state_t;

    typedef struct packed {
        op_t               kind;
        logic [RAM_AW-1:0] mem_addr;
        logic [7:0]        wdata;
        logic              echo;
        logic              boot_window;
    } dec_t;

endpackage

`default_nettype wire

### hdl/hmmap_front.sv
`default_nettype none

module hmmap_front
(
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [23:0]        s_tdata,   // address[15:0], write_data[23:16]
    input  wire logic [1:0]         s_tuser,   // cmd[1:0]
    input  wire logic               clearing,
    input  wire logic               q_ready,
    output logic                    q_push,
    output hmmap_pkg::dec_t         q_entry
);

    logic [15:0] addr;
    logic [7:0]  data;
    logic [15:0] shifted;
    logic        is_rom;
    logic        is_echo;
    logic [hmmap_pkg::RAM_AW-1:0] ram_idx;

    always_comb
    begin
        addr    = s_tdata[15:0];
        data    = s_tdata[23:16];
        shifted = addr - hmmap_pkg::ECHO_SHIFT;
        is_rom  = addr <= hmmap_pkg::ROM_TOP;
        is_echo = (addr >= hmmap_pkg::ECHO_LO) && (addr <= hmmap_pkg::ECHO_HI);
        ram_idx = is_echo ? shifted[hmmap_pkg::RAM_AW-1:0] : addr[hmmap_pkg::RAM_AW-1:0];
    end

    always_comb
    begin
        q_entry.kind        = hmmap_pkg::OP_NOP;
        q_entry.mem_addr    = ram_idx;
        q_entry.wdata       = data;
        q_entry.echo        = 1'b0;
        q_entry.boot_window = addr <= hmmap_pkg::BOOT_TOP;
        case (hmmap_pkg::cmd_t'(s_tuser))
            hmmap_pkg::CMD_READ:
            begin
                q_entry.echo = is_echo;
                if (is_rom)
                begin
                    q_entry.kind     = hmmap_pkg::OP_RD_ROM;
                    q_entry.mem_addr = addr[hmmap_pkg::RAM_AW-1:0];
                end
                else
                begin
                    q_entry.kind = hmmap_pkg::OP_RD_RAM;
                end
            end
            hmmap_pkg::CMD_WRITE:
            begin
                q_entry.echo = is_echo;
                if (is_rom)
                    q_entry.kind = hmmap_pkg::OP_NOP;
                else if (addr == hmmap_pkg::DMA_ADDR)
                    q_entry.kind = hmmap_pkg::OP_DMA;
                else
                    q_entry.kind = hmmap_pkg::OP_WR_RAM;
                // joypad register keeps its low nibble high
                if (addr == hmmap_pkg::JOYPAD_ADDR)
                    q_entry.wdata = data | hmmap_pkg::JOYPAD_MASK;
            end
            hmmap_pkg::CMD_LOAD_CART:
            begin
                q_entry.kind     = hmmap_pkg::OP_LD_CART;
                q_entry.mem_addr = addr[hmmap_pkg::RAM_AW-1:0];
            end
            hmmap_pkg::CMD_LOAD_BOOT:
            begin
                q_entry.kind     = hmmap_pkg::OP_LD_BOOT;
                q_entry.mem_addr = {{(hmmap_pkg::RAM_AW-hmmap_pkg::BOOT_AW){1'b0}},
                                    addr[hmmap_pkg::BOOT_AW-1:0]};
            end
            default:
            begin
                q_entry.kind = hmmap_pkg::OP_NOP;
            end
        endcase
    end

    assign s_tready = q_ready && !clearing;
    assign q_push   = s_tvalid && s_tready;

endmodule

`default_nettype wire

### hdl/hmmap_queue.sv
`default_nettype none

module hmmap_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire hmmap_pkg::dec_t push_entry,
    output logic                 push_ready,
    input  wire logic            pop,
    output logic                 pop_valid,
    output hmmap_pkg::dec_t      pop_entry
);

    hmmap_pkg::dec_t entries_reg [hmmap_pkg::QUEUE_DEPTH];
    logic [hmmap_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [hmmap_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [hmmap_pkg::QCNT_W-1:0] count_reg, count_next;
    logic do_pop;

    assign push_ready = count_reg != hmmap_pkg::QCNT_W'(hmmap_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = entries_reg[rd_ptr_reg];
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == hmmap_pkg::QPTR_W'(hmmap_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == hmmap_pkg::QPTR_W'(hmmap_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

### hdl/hmmap_back.sv
`default_nettype none

module hmmap_back
#(
    parameter int OAM_DMA_BYTES = 160
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire hmmap_pkg::dec_t q_entry,
    output logic                 q_pop,
    output logic                 clearing,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [7:0]           m_tdata,   // read_data[7:0]
    output logic [0:0]           m_tuser    // echo_access
);

    localparam int AW = hmmap_pkg::RAM_AW;
    localparam int BW = hmmap_pkg::BOOT_AW;
    localparam int OW = hmmap_pkg::OFFSET_W;

    logic [7:0] ram_mem  [hmmap_pkg::RAM_DEPTH];
    logic [7:0] cart_mem [hmmap_pkg::RAM_DEPTH];
    logic [7:0] boot_mem [hmmap_pkg::BOOT_DEPTH];

    hmmap_pkg::back_state_t state_reg, state_next;

    logic          ram_we, cart_we, boot_we;
    logic [AW-1:0] ram_addr, cart_addr;
    logic [BW-1:0] boot_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata_reg, cart_rdata_reg, boot_rdata_reg;

    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          boot_off_reg, boot_off_next;
    logic [7:0]    dma_page_reg, dma_page_next;
    logic [OW-1:0] dma_offset_reg, dma_offset_next;
    hmmap_pkg::src_t src_reg, src_next;
    logic          echo_pend_reg, echo_pend_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_data_reg, out_data_next;
    logic          out_echo_reg, out_echo_next;
    logic          load_out;
    logic [7:0]    load_data;
    logic          load_echo;
    logic          can_start;
    logic          start;

    logic [7:0]    rd_mux;
    logic [7:0]    src_page;
    logic [7:0]    echo_page;

    assign can_start = !out_valid_reg || m_tready;
    assign start     = (state_reg == hmmap_pkg::ST_IDLE) && q_valid && can_start;
    assign clearing  = state_reg == hmmap_pkg::ST_CLEAR;
    assign echo_page = dma_page_reg - hmmap_pkg::ECHO_PAGE_SUB;

    always_comb
    begin
        case (src_reg)
            hmmap_pkg::SRC_CART: rd_mux = cart_rdata_reg;
            hmmap_pkg::SRC_BOOT: rd_mux = boot_rdata_reg;
            default:             rd_mux = ram_rdata_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hmmap_pkg::ST_CLEAR:
                if (clr_cnt_reg == {AW{1'b1}})
                    state_next = hmmap_pkg::ST_IDLE;
            hmmap_pkg::ST_IDLE:
                if (start)
                begin
                    if (q_entry.kind == hmmap_pkg::OP_RD_ROM ||
                        q_entry.kind == hmmap_pkg::OP_RD_RAM)
                        state_next = hmmap_pkg::ST_RESP;
                    else if (q_entry.kind == hmmap_pkg::OP_DMA)
                        state_next = hmmap_pkg::ST_DMA_RD;
                end
            hmmap_pkg::ST_RESP:
                state_next = hmmap_pkg::ST_IDLE;
            hmmap_pkg::ST_DMA_RD:
                state_next = hmmap_pkg::ST_DMA_WR;
            hmmap_pkg::ST_DMA_WR:
                if (dma_offset_reg == OW'(OAM_DMA_BYTES - 1))
                    state_next = hmmap_pkg::ST_DMA_FIN;
                else
                    state_next = hmmap_pkg::ST_DMA_RD;
            hmmap_pkg::ST_DMA_FIN:
                state_next = hmmap_pkg::ST_IDLE;
            default:
                state_next = hmmap_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath controls
    always_comb
    begin
        ram_we          = 1'b0;
        cart_we         = 1'b0;
        boot_we         = 1'b0;
        ram_addr        = q_entry.mem_addr;
        cart_addr       = q_entry.mem_addr;
        boot_addr       = q_entry.mem_addr[BW-1:0];
        ram_wdata       = q_entry.wdata;
        q_pop           = 1'b0;
        load_out        = 1'b0;
        load_data       = 8'h00;
        load_echo       = 1'b0;
        clr_cnt_next    = clr_cnt_reg;
        boot_off_next   = boot_off_reg;
        dma_page_next   = dma_page_reg;
        dma_offset_next = dma_offset_reg;
        src_next        = src_reg;
        echo_pend_next  = echo_pend_reg;
        src_page        = dma_page_reg;

        case (state_reg)
            hmmap_pkg::ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                ram_wdata    = 8'h00;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            hmmap_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    q_pop          = 1'b1;
                    echo_pend_next = q_entry.echo;
                    case (q_entry.kind)
                        hmmap_pkg::OP_RD_ROM:
                            if (q_entry.boot_window && !boot_off_reg)
                                src_next = hmmap_pkg::SRC_BOOT;
                            else
                                src_next = hmmap_pkg::SRC_CART;
                        hmmap_pkg::OP_RD_RAM:
                            src_next = hmmap_pkg::SRC_RAM;
                        hmmap_pkg::OP_WR_RAM:
                        begin
                            ram_we    = 1'b1;
                            load_out  = 1'b1;
                            load_echo = q_entry.echo;
                            if (q_entry.mem_addr == hmmap_pkg::BOOT_OFF_IDX)
                                boot_off_next = q_entry.wdata == hmmap_pkg::BOOT_OFF_VAL;
                        end
                        hmmap_pkg::OP_DMA:
                        begin
                            dma_page_next   = q_entry.wdata;
                            dma_offset_next = '0;
                        end
                        hmmap_pkg::OP_LD_CART:
                        begin
                            cart_we  = 1'b1;
                            load_out = 1'b1;
                        end
                        hmmap_pkg::OP_LD_BOOT:
                        begin
                            boot_we  = 1'b1;
                            load_out = 1'b1;
                        end
                        default:
                        begin
                            load_out  = 1'b1;
                            load_echo = q_entry.echo;
                        end
                    endcase
                end
            end
            hmmap_pkg::ST_RESP:
            begin
                load_out  = 1'b1;
                load_data = rd_mux;
                load_echo = echo_pend_reg;
            end
            hmmap_pkg::ST_DMA_RD:
            begin
                // source byte decoded as a cpu read of {page, offset}
                if (!dma_page_reg[7])
                begin
                    cart_addr = {dma_page_reg[6:0], dma_offset_reg};
                    boot_addr = dma_offset_reg;
                    if (dma_page_reg == 8'h00 && !boot_off_reg)
                        src_next = hmmap_pkg::SRC_BOOT;
                    else
                        src_next = hmmap_pkg::SRC_CART;
                end
                else
                begin
                    if (dma_page_reg >= hmmap_pkg::ECHO_PAGE_LO &&
                        dma_page_reg <= hmmap_pkg::ECHO_PAGE_HI)
                        src_page = echo_page;
                    ram_addr = {src_page[6:0], dma_offset_reg};
                    src_next = hmmap_pkg::SRC_RAM;
                end
            end
            hmmap_pkg::ST_DMA_WR:
            begin
                ram_we          = 1'b1;
                ram_addr        = hmmap_pkg::OAM_BASE_IDX + AW'(dma_offset_reg);
                ram_wdata       = rd_mux;
                dma_offset_next = dma_offset_reg + 1'b1;
            end
            hmmap_pkg::ST_DMA_FIN:
            begin
                ram_we    = 1'b1;
                ram_addr  = hmmap_pkg::DMA_REG_IDX;
                ram_wdata = dma_page_reg;
                load_out  = 1'b1;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_echo_next  = out_echo_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = load_data;
            out_echo_next  = load_echo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hmmap_pkg::ST_CLEAR;
            clr_cnt_reg    <= '0;
            boot_off_reg   <= 1'b0;
            dma_page_reg   <= '0;
            dma_offset_reg <= '0;
            src_reg        <= hmmap_pkg::SRC_RAM;
            echo_pend_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            boot_off_reg   <= boot_off_next;
            dma_page_reg   <= dma_page_next;
            dma_offset_reg <= dma_offset_next;
            src_reg        <= src_next;
            echo_pend_reg  <= echo_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_echo_reg <= out_echo_next;
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
            ram_mem[ram_addr] <= ram_wdata;
        ram_rdata_reg <= ram_mem[ram_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cart_we)
            cart_mem[cart_addr] <= q_entry.wdata;
        cart_rdata_reg <= cart_mem[cart_addr];
    end

    always_ff @(posedge clk)
    begin
        if (boot_we)
            boot_mem[boot_addr] <= q_entry.wdata;
        boot_rdata_reg <= boot_mem[boot_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_echo_reg;

    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !q_pop)
        else $error("queue popped during ram clear");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten before transfer");

    a_dma_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hmmap_pkg::ST_DMA_RD) |-> (dma_offset_reg < OW'(OAM_DMA_BYTES)))
        else $error("dma offset past end of copy");

    a_dma_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hmmap_pkg::ST_DMA_FIN) |=> (state_reg == hmmap_pkg::ST_IDLE &&
                                                  dma_offset_reg == OW'(OAM_DMA_BYTES)))
        else $error("dma did not finish with full count");

endmodule

`default_nettype wire

### hdl/handheld_memory_map_with_oam_dma.sv
// channel   | dir | tdata                              | tuser
// s_axis    | in  | address[15:0], write_data[23:16]   | cmd[1:0]
// m_axis    | out | read_data[7:0]                     | echo_access[0]
//
// one result per input transfer, in order; a 2-entry queue separates decode from execution
// executor reads pass the memory read, then the result register; other non-dma items load it directly
// a write to 0xff46 copies OAM_DMA_BYTES bytes: one source read and one ram port write per byte
// after reset a clearing pass zeroes the 32768-byte ram, one byte a cycle; s_axis_tready is low then
// a result waiting on m_axis_tready holds the executor, while the queue keeps taking input until full
`default_nettype none

module handheld_memory_map_with_oam_dma
#(
    parameter int OAM_DMA_BYTES = 160
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // address[15:0], write_data[23:16]
    input  wire logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // read_data[7:0]
    output logic [0:0]       m_axis_tuser    // echo_access
);

    logic            clearing;
    logic            q_ready;
    logic            q_push;
    hmmap_pkg::dec_t q_in_entry;
    logic            q_pop;
    logic            q_valid;
    hmmap_pkg::dec_t q_out_entry;

    hmmap_front u_front
    (
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .clearing (clearing),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_entry  (q_in_entry)
    );

    hmmap_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in_entry),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_out_entry)
    );

    hmmap_back #(
        .OAM_DMA_BYTES (OAM_DMA_BYTES)
    ) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_entry  (q_out_entry),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire
